[hw/rtl/aopm_pkg.sv]
package aopm_pkg;

   localparam int CHANNELS_DEF = 2;

   localparam int SAMPLE_W = 10;
   localparam int RANGE_W  = 3;
   localparam int POWER_W  = 14;
   localparam int LOGT_W   = 12;
   localparam int SUM_W    = 15;
   localparam int STEP_W   = 13;

   localparam logic [RANGE_W-1:0] RANGE_MAX = 3'd7;

   localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST  = 10'd40;
   localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST = 10'd1000;
   localparam logic signed [POWER_W-1:0] THRESHOLD_RST = -14'sd4000;

   localparam logic signed [POWER_W-1:0] PWR_MAX    = 14'sd3000;
   localparam logic signed [POWER_W-1:0] PWR_MIN    = -14'sd5000;
   localparam logic signed [SUM_W-1:0]   PWR_OFFSET = 15'sd2000;
   localparam logic [STEP_W-1:0]         PWR_STEP   = 13'd1000;

   localparam int LOGT_DEPTH = 1 << SAMPLE_W;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_LOW_LIMIT  = 2'd0,
      CSR_HIGH_LIMIT = 2'd1,
      CSR_THRESH_CH0 = 2'd2,
      CSR_THRESH_CH1 = 2'd3
   } csr_index_type;

   // one channel's state word
   typedef struct packed {
      logic [RANGE_W-1:0]        gain_range;
      logic signed [POWER_W-1:0] power_level;
      logic                      alarm;
      logic signed [POWER_W-1:0] alarm_level;
   } entry_type;

   typedef logic signed [LOGT_W-1:0] logt_rom_type [LOGT_DEPTH];

   // log2(s) in Q30 by repeated squaring, truncating
   function automatic logic [63:0] log2_q30(input logic [SAMPLE_W-1:0] s);
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] k;
      k = 64'd0;
      frac = 64'd0;
      for (int i = 1; i <= SAMPLE_W; i++) begin
         if ((s >> i) != 0) k = 64'(i);
      end
      x = 64'(s) << (64'd30 - k);
      for (int i = 0; i < 30; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            frac = frac | 64'd1;
         end
      end
      return (k << 30) | frac;
   endfunction

   // round(1000*log10(s/80)), built at elaboration
   function automatic logt_rom_type build_logt_rom();
      logt_rom_type rom;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] mag;
      logic [63:0] prod;
      b = log2_q30(10'd80);
      rom[0] = '0;
      for (int s = 1; s < LOGT_DEPTH; s++) begin
         a = log2_q30(SAMPLE_W'(s));
         mag = (a < b) ? (b - a) : (a - b);
         prod = (mag * 64'd315652829 + (64'd1 << 49)) >> 50;
         rom[s] = (a < b) ? -$signed(LOGT_W'(prod)) : $signed(LOGT_W'(prod));
      end
      return rom;
   endfunction

endpackage

[hw/rtl/autorange_optical_power_meter.sv]
// Autoranging optical power meter, one detector sample per item.
// From req accept to rsp_tvalid: registered state/ROM read, then registered update.
// Throughput: one item per cycle while rsp_tready does not stall the output; the
// state memory's single read and write port per cycle sets this, with same-channel
// back-to-back items forwarded. Reset: synchronous, active high; ranges, powers,
// alarms read as zero and the csr registers return to their defaults.
module autorange_optical_power_meter
   import aopm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [9:0] sample, [15:10] zero
   input  logic [0:0]  req_tuser,  // [0] channel
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [2:0] gain_range, [16:3] power_level,
                                   // [17] alarm, [31:18] alarm_level
   output logic [1:0]  rsp_tuser,  // [0] out_channel, [1] measured
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // log table, one entry per sample code; entry for zero is never used
   localparam logt_rom_type LOGT_ROM = build_logt_rom();

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [SAMPLE_W-1:0]        low_limit_ff;
   logic [SAMPLE_W-1:0]        high_limit_ff;
   logic signed [POWER_W-1:0]  thresh0_ff;
   logic signed [POWER_W-1:0]  thresh1_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= LOW_LIMIT_RST;
         high_limit_ff <= HIGH_LIMIT_RST;
         thresh0_ff    <= THRESHOLD_RST;
         thresh1_ff    <= THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LOW_LIMIT:  low_limit_ff  <= csr_data[SAMPLE_W-1:0];
            CSR_HIGH_LIMIT: high_limit_ff <= csr_data[SAMPLE_W-1:0];
            CSR_THRESH_CH0: thresh0_ff    <= $signed(csr_data);
            CSR_THRESH_CH1: thresh1_ff    <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pipeline control
   // ---------------------------------------------------------------
   logic                 req_accept;
   logic                 req_present;
   logic [CH_W-1:0]      req_idx;

   logic                 a_valid_ff;
   logic [CH_W-1:0]      a_idx_ff;
   logic                 a_channel_ff;
   logic [SAMPLE_W-1:0]  a_sample_ff;
   entry_type            a_entry_ff;     // channel state as read (or forwarded)
   logic signed [LOGT_W-1:0] a_logt_ff;
   logic                 a_move;

   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;
   logic [1:0]           rsp_user_ff;

   assign a_move      = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !a_valid_ff || a_move;
   assign req_accept  = req_tvalid && req_tready;
   assign req_idx     = CH_W'(req_tuser[0]);
   // an absent channel is taken and dropped
   assign req_present = (32'(req_tuser[0]) < CHANNELS);

   // ---------------------------------------------------------------
   // channel state memory, one entry per channel, valid bits for reset
   // ---------------------------------------------------------------
   entry_type            state_mem [CHANNELS];
   logic [CHANNELS-1:0]  state_vld_ff;
   entry_type            wr_entry;

   always_ff @(posedge clock) begin
      if (a_move) begin
         state_mem[a_idx_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_vld_ff <= '0;
      end else if (a_move) begin
         state_vld_ff[a_idx_ff] <= 1'b1;
      end
   end

   // read on accept; a write to the same channel at this edge is forwarded
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (a_move && a_idx_ff == req_idx) begin
            a_entry_ff <= wr_entry;
         end else if (state_vld_ff[req_idx]) begin
            a_entry_ff <= state_mem[req_idx];
         end else begin
            a_entry_ff <= '0;
         end
         a_logt_ff    <= LOGT_ROM[req_tdata[SAMPLE_W-1:0]];
         a_idx_ff     <= req_idx;
         a_channel_ff <= req_tuser[0];
         a_sample_ff  <= req_tdata[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_accept && req_present;
      end
   end

   // ---------------------------------------------------------------
   // range decision and power computation
   // ---------------------------------------------------------------
   logic [RANGE_W-1:0]        cur_range;
   logic                      step_up;
   logic                      step_down;
   logic                      measured;
   logic [STEP_W-1:0]         range_step;
   logic signed [SUM_W-1:0]   power_sum;
   logic signed [POWER_W-1:0] power_val;
   logic signed [POWER_W-1:0] thresh;
   logic                      alarm_hit;

   assign cur_range = a_entry_ff.gain_range;
   assign step_up   = (a_sample_ff < low_limit_ff) && (cur_range != RANGE_MAX);
   assign step_down = !step_up && (a_sample_ff > high_limit_ff) && (cur_range != '0);
   assign measured  = !step_up && !step_down;
   assign thresh    = a_channel_ff ? thresh1_ff : thresh0_ff;

   always_comb begin
      range_step = STEP_W'(cur_range) * PWR_STEP;
      power_sum  = SUM_W'(a_logt_ff) + PWR_OFFSET - $signed({2'b00, range_step});
      if (a_sample_ff == '0) begin
         power_val = PWR_MIN;
      end else if (power_sum > SUM_W'(PWR_MAX)) begin
         power_val = PWR_MAX;
      end else if (power_sum < SUM_W'(PWR_MIN)) begin
         power_val = PWR_MIN;
      end else begin
         power_val = POWER_W'(power_sum);
      end
      alarm_hit = (power_val <= thresh);

      wr_entry = a_entry_ff;
      if (step_up) begin
         wr_entry.gain_range = cur_range + 3'd1;
      end else if (step_down) begin
         wr_entry.gain_range = cur_range - 3'd1;
      end else begin
         wr_entry.power_level = power_val;
         wr_entry.alarm       = alarm_hit;
         if (alarm_hit) wr_entry.alarm_level = power_val;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         rsp_data_ff <= {wr_entry.alarm_level, wr_entry.alarm,
                         wr_entry.power_level, wr_entry.gain_range};
         rsp_user_ff <= {measured, a_channel_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // forwarded read must carry what the previous item wrote
   a_fwd_check: assert property (@(posedge clock) disable iff (reset)
      (req_accept && a_move && a_idx_ff == req_idx) |=> (a_entry_ff == $past(wr_entry)))
      else $error("forwarded channel state mismatch");

   // the range moves by at most one step per item
   a_range_step: assert property (@(posedge clock) disable iff (reset)
      a_move |-> (wr_entry.gain_range == cur_range ||
                  wr_entry.gain_range == cur_range + 3'd1 ||
                  wr_entry.gain_range == cur_range - 3'd1))
      else $error("range moved by more than one step");

   // an item leaving the update stage always lands in the result register
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      a_move |=> rsp_valid_ff)
      else $error("result lost");
`endif

endmodule
